@@ rtl/core/oahs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahs_pkg
// Shared constants and codes for the open addressing hash set core.
// ----------------------------------------------------------------------------
package oahs_pkg;

	// Default geometry
	localparam int LOG2_SLOTS_DEF = 10;
	localparam int KEY_BITS_DEF   = 32;

	// Fixed port widths
	localparam int KEY_W    = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	// Hash constants: home = key*HOME_MUL, each probe adds PROBE_STEP
	localparam int HOME_MUL   = 73;
	localparam int PROBE_STEP = 5009;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_TEST   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT_ALREADY = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_PRESENT  = 3'd4,
		ST_INVALID  = 3'd5,
		ST_FULL     = 3'd6
	} status_t;

endpackage

@@ rtl/core/oahs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oahs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module oahs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/open_addressing_hash_set_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_set_core
// Open addressing hash set with tombstones: add, remove and member test.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                          Handshake
// -------   ----------------------------------------------   -------------------
// command   cmd, key                                         start & !busy
// result    status, slot_index, live_count, tombstone_count  done, one cycle
//
// Probing: busy stays high from the accept edge while the command walks its
// probe chain (one slot read per cycle from the slot RAM); done rises on
// the cycle busy falls, so the next command can be taken then.
// A reserved key (0 or 1) answers on the next cycle with no probe.
// Reset: after arst_n releases, busy stays high while a clearing pass
// writes every slot empty.
// The receiver cannot stall; done is high for one cycle and the result word holds until the next result.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_core #(
	parameter int LOG2_SLOTS = oahs_pkg::LOG2_SLOTS_DEF,
	parameter int KEY_BITS   = oahs_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [oahs_pkg::CMD_W-1:0]    cmd,
	input  logic [oahs_pkg::KEY_W-1:0]    key,
	output logic                          done,
	output logic [oahs_pkg::STATUS_W-1:0] status,
	output logic [LOG2_SLOTS-1:0]         slot_index,
	output logic [LOG2_SLOTS:0]           live_count,
	output logic [LOG2_SLOTS:0]           tombstone_count
);

	import oahs_pkg::*;

	localparam int NSLOTS = 1 << LOG2_SLOTS;
	localparam logic [LOG2_SLOTS-1:0] MUL_L  = LOG2_SLOTS'(HOME_MUL);
	localparam logic [LOG2_SLOTS-1:0] STEP_L = LOG2_SLOTS'(PROBE_STEP);
	localparam logic [KEY_BITS-1:0]   VAL_EMPTY = '0;
	localparam logic [KEY_BITS-1:0]   VAL_TOMB  = {{(KEY_BITS-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXAM
	} state_t;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	state_t                  state_q;
	logic [LOG2_SLOTS-1:0]   idx_q;       // slot under examination / clear pointer
	logic [LOG2_SLOTS-1:0]   n_q;         // probes done before this one
	logic [CMD_W-1:0]        cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic                    tomb_ok_q;   // a tombstone was passed
	logic [LOG2_SLOTS-1:0]   tomb_q;      // first tombstone passed
	logic [LOG2_SLOTS:0]     live_q;
	logic [LOG2_SLOTS:0]     dead_q;
	logic                    done_q;
	logic [STATUS_W-1:0]     status_q;
	logic [LOG2_SLOTS-1:0]   slot_q;

	// ------------------------------------------------------------------
	// Input word decode
	// ------------------------------------------------------------------
	logic                  accept;
	logic [KEY_BITS-1:0]   key_k;
	logic [LOG2_SLOTS-1:0] key_lo;
	logic [LOG2_SLOTS-1:0] home;
	logic                  key_bad;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign key_k   = KEY_BITS'(key);
	assign key_lo  = LOG2_SLOTS'(key_k);
	assign home    = LOG2_SLOTS'(key_lo * MUL_L);
	assign key_bad = (key_k == VAL_EMPTY) || (key_k == VAL_TOMB);

	// ------------------------------------------------------------------
	// Slot RAM
	// ------------------------------------------------------------------
	logic                  ram_we;
	logic [LOG2_SLOTS-1:0] ram_waddr;
	logic [KEY_BITS-1:0]   ram_wdata;
	logic [LOG2_SLOTS-1:0] ram_raddr;
	logic [KEY_BITS-1:0]   ram_rdata;
	logic [LOG2_SLOTS-1:0] idx_next;

	assign idx_next = idx_q + STEP_L;

	// In idle, fetch the home slot of the word on the port; while probing,
	// fetch the next slot of the chain so one slot is examined per cycle.
	assign ram_raddr = (state_q == S_IDLE) ? home : idx_next;

	oahs_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(NSLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Probe examination and final update
	// ------------------------------------------------------------------
	logic                  is_empty;
	logic                  is_tomb;
	logic                  is_hit;
	logic                  last;
	logic                  fin;
	logic                  tomb_any;
	logic [LOG2_SLOTS-1:0] tomb_addr;
	logic                  upd_we;
	logic [LOG2_SLOTS-1:0] upd_addr;
	logic [KEY_BITS-1:0]   upd_data;
	logic [STATUS_W-1:0]   st_n;
	logic [LOG2_SLOTS-1:0] slot_n;
	logic [LOG2_SLOTS:0]   live_n;
	logic [LOG2_SLOTS:0]   dead_n;

	assign is_empty  = (ram_rdata == VAL_EMPTY);
	assign is_tomb   = (ram_rdata == VAL_TOMB);
	assign is_hit    = (ram_rdata == key_q);
	assign last      = &n_q;
	assign fin       = (state_q == S_EXAM) && (is_empty || is_hit || last);
	// First tombstone of the chain, counting the slot in hand
	assign tomb_any  = tomb_ok_q || is_tomb;
	assign tomb_addr = tomb_ok_q ? tomb_q : idx_q;

	always_comb begin
		upd_we   = 1'b0;
		upd_addr = idx_q;
		upd_data = key_q;
		st_n     = ST_ABSENT;
		slot_n   = '0;
		live_n   = live_q;
		dead_n   = dead_q;
		unique case (cmd_q)
			CMD_ADD: begin
				if (is_hit) begin
					st_n   = ST_PRESENT_ALREADY;
					slot_n = idx_q;
				end else if (tomb_any) begin
					// reuse the first tombstone
					upd_we   = 1'b1;
					upd_addr = tomb_addr;
					st_n     = ST_INSERTED;
					slot_n   = tomb_addr;
					live_n   = live_q + 1'b1;
					dead_n   = dead_q - 1'b1;
				end else if (is_empty) begin
					upd_we = 1'b1;
					st_n   = ST_INSERTED;
					slot_n = idx_q;
					live_n = live_q + 1'b1;
				end else begin
					st_n = ST_FULL;
				end
			end
			CMD_REMOVE: begin
				if (is_hit) begin
					upd_we   = 1'b1;
					upd_data = VAL_TOMB;
					st_n     = ST_REMOVED;
					slot_n   = idx_q;
					live_n   = live_q - 1'b1;
					dead_n   = dead_q + 1'b1;
				end
			end
			default: begin
				// membership test; the unused code acts the same
				if (is_hit) begin
					st_n   = ST_PRESENT;
					slot_n = idx_q;
				end
			end
		endcase
	end

	// Clearing pass owns the write port until it ends
	assign ram_we    = (state_q == S_CLEAR) || (fin && upd_we);
	assign ram_waddr = (state_q == S_CLEAR) ? idx_q : upd_addr;
	assign ram_wdata = (state_q == S_CLEAR) ? VAL_EMPTY : upd_data;

	// ------------------------------------------------------------------
	// Sequencer and result word
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			idx_q     <= '0;
			n_q       <= '0;
			tomb_ok_q <= 1'b0;
			live_q    <= '0;
			dead_q    <= '0;
			done_q    <= 1'b0;
			cmd_q     <= '0;
			key_q     <= '0;
			tomb_q    <= '0;
			status_q  <= '0;
			slot_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					// sweep every slot to empty
					idx_q <= idx_q + 1'b1;
					if (&idx_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (key_bad) begin
							// reserved key: answer at once, touch nothing
							done_q   <= 1'b1;
							status_q <= ST_INVALID;
							slot_q   <= '0;
						end else begin
							state_q   <= S_EXAM;
							cmd_q     <= cmd;
							key_q     <= key_k;
							idx_q     <= home;
							n_q       <= '0;
							tomb_ok_q <= 1'b0;
						end
					end
				end
				S_EXAM: begin
					if (fin) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= st_n;
						slot_q   <= slot_n;
						live_q   <= live_n;
						dead_q   <= dead_n;
					end else begin
						// advance along the chain; the read of idx_next is in flight
						idx_q <= idx_next;
						n_q   <= n_q + 1'b1;
						if (is_tomb && !tomb_ok_q) begin
							tomb_ok_q <= 1'b1;
							tomb_q    <= idx_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign slot_index      = slot_q;
	assign live_count      = live_q;
	assign tombstone_count = dead_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(fin) || $past(accept && key_bad))
		else $error("result word without a finished command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, live_q} + {1'b0, dead_q}) <= (LOG2_SLOTS + 2)'(NSLOTS))
		else $error("key and tombstone counts exceed slot count");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR) || fin)
		else $error("slot write outside clear pass or command end");

	a_probe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXAM && !fin) |=>
			(state_q == S_EXAM) && (n_q == $past(n_q) + 1'b1))
		else $error("probe chain did not advance");

	a_stats_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> $stable(live_q) && $stable(dead_q))
		else $error("counts changed without a finished command");

endmodule
